[src/ffa_pkg.sv]
package ffa_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ALLOC   = 3'd1;
    localparam logic [2:0] S_FIND    = 3'd2;
    localparam logic [2:0] S_MERGE_B = 3'd3;
    localparam logic [2:0] S_MERGE_C = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    localparam int RECIP_SHIFT = 18;
    localparam int BYTES_W     = 10;
    localparam int ROUND_W     = 11;
    localparam int ARITH_W     = 22;

endpackage

[src/ffa_cell.sv]
module ffa_cell
    import ffa_pkg::*;
#(
    parameter int GW        = 7,
    parameter bit RST_START = 1'b0,
    parameter int RST_GRAN  = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic          bwd,
    input  logic          fwd_start,
    input  logic          fwd_used,
    input  logic [GW-1:0] fwd_gran,
    input  logic          bwd_start,
    input  logic          bwd_used,
    input  logic [GW-1:0] bwd_gran,
    output logic          start,
    output logic          used,
    output logic [GW-1:0] gran
);

    logic          start_reg;
    logic          used_reg;
    logic [GW-1:0] gran_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= RST_START;
            used_reg  <= 1'b0;
            gran_reg  <= GW'(RST_GRAN);
        end
        else if (shift)
        begin
            if (bwd)
            begin
                start_reg <= bwd_start;
                used_reg  <= bwd_used;
                gran_reg  <= bwd_gran;
            end
            else
            begin
                start_reg <= fwd_start;
                used_reg  <= fwd_used;
                gran_reg  <= fwd_gran;
            end
        end
    end

    assign start = start_reg;
    assign used  = used_reg;
    assign gran  = gran_reg;

endmodule

[src/first_fit_block_allocator.sv]
// an allocate walks the cell ring once and its response is then loaded; a free walks it
// once when the address is missing and, when the address is found, twice more
// as the merge walks the cell ring down and then up again
// one request at a time: the next is taken in the cycle after the response is loaded,
// later while an earlier response is still stalled
// reset (rst_n low, asynchronous) leaves a single free block spanning the arena
module first_fit_block_allocator
    import ffa_pkg::*;
#(
    parameter int ARENA_BYTES  = 1024,
    parameter int ALIGN_BYTES  = 16,
    parameter int HEADER_BYTES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                operation,
    input  logic [BYTES_W-1:0]  request_bytes,
    input  logic [BYTES_W-1:0]  free_offset,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [1:0]          status,
    output logic [BYTES_W-1:0]  data_offset
);

    localparam int NUM_G  = ARENA_BYTES / ALIGN_BYTES;
    localparam int HDR_G  = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PW     = (NUM_G > 1) ? $clog2(NUM_G) : 1;
    localparam int GW     = $clog2(NUM_G + HDR_G + 1);
    localparam int GRAN0  = (NUM_G > HDR_G) ? NUM_G - HDR_G : 0;
    localparam int RECIP  = ((1 << RECIP_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int RCW    = $clog2(RECIP + 1);

    logic          c_start [NUM_G];
    logic          c_used  [NUM_G];
    logic [GW-1:0] c_gran  [NUM_G];

    logic          p_start;
    logic          p_used;
    logic [GW-1:0] p_gran;

    logic [2:0]         state_reg, state_next;
    logic [PW-1:0]      cnt_reg;
    logic               op_reg;
    logic [BYTES_W-1:0] req_reg;
    logic [BYTES_W-1:0] off_reg;
    logic [ROUND_W-1:0] r_reg;
    logic               found_reg, found_next;
    logic               pend_reg, pend_next;
    logic [PW-1:0]      pend_pos_reg, pend_pos_next;
    logic [GW-1:0]      pend_gran_reg, pend_gran_next;
    logic               flag_reg, flag_next;
    logic [GW-1:0]      span_reg, span_next;
    logic [BYTES_W-1:0] res_off_reg, res_off_next;
    logic [1:0]         res_st_reg;
    logic               rsp_valid_reg;
    logic [1:0]         status_reg;
    logic [BYTES_W-1:0] offset_reg;

    logic               shift;
    logic               bwd;
    logic               last;
    logic               h_start;
    logic               h_used;
    logic [GW-1:0]      h_gran;
    logic [ARITH_W-1:0] gran_w, pos_w, hdr_w, align_w, req_w, r_w, s_w, data_w, sum_w;
    logic [ROUND_W+RCW-1:0] recip_prod;
    logic               fit;
    logic               split;

    genvar i;
    generate
        for (i = 0; i < NUM_G; i++)
        begin : g_cell
            logic          f_start, f_used, b_start, b_used;
            logic [GW-1:0] f_gran, b_gran;
            if (i == NUM_G - 1)
            begin : g_fl
                assign f_start = p_start;
                assign f_used  = p_used;
                assign f_gran  = p_gran;
            end
            else
            begin : g_fm
                assign f_start = c_start[i+1];
                assign f_used  = c_used[i+1];
                assign f_gran  = c_gran[i+1];
            end
            if (i == 0)
            begin : g_bf
                assign b_start = p_start;
                assign b_used  = p_used;
                assign b_gran  = p_gran;
            end
            else
            begin : g_bm
                assign b_start = c_start[i-1];
                assign b_used  = c_used[i-1];
                assign b_gran  = c_gran[i-1];
            end
            ffa_cell #(
                .GW        (GW),
                .RST_START (i == 0),
                .RST_GRAN  ((i == 0) ? GRAN0 : 0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .bwd       (bwd),
                .fwd_start (f_start),
                .fwd_used  (f_used),
                .fwd_gran  (f_gran),
                .bwd_start (b_start),
                .bwd_used  (b_used),
                .bwd_gran  (b_gran),
                .start     (c_start[i]),
                .used      (c_used[i]),
                .gran      (c_gran[i])
            );
        end
    endgenerate

    assign shift = (state_reg == S_ALLOC) || (state_reg == S_FIND) ||
                   (state_reg == S_MERGE_B) || (state_reg == S_MERGE_C);
    assign bwd   = (state_reg == S_MERGE_B);
    assign last  = (cnt_reg == PW'(NUM_G - 1));

    assign h_start = bwd ? c_start[NUM_G-1] : c_start[0];
    assign h_used  = bwd ? c_used[NUM_G-1]  : c_used[0];
    assign h_gran  = bwd ? c_gran[NUM_G-1]  : c_gran[0];

    // request rounded up to granules by reciprocal multiply
    assign recip_prod = (ROUND_W+RCW)'(ROUND_W'(request_bytes) + ROUND_W'(ALIGN_BYTES - 1))
                        * (ROUND_W+RCW)'(RECIP);

    assign gran_w  = ARITH_W'(h_gran);
    assign pos_w   = ARITH_W'(cnt_reg);
    assign hdr_w   = ARITH_W'(HDR_G);
    assign align_w = ARITH_W'(ALIGN_BYTES);
    assign req_w   = ARITH_W'(req_reg);
    assign r_w     = ARITH_W'(r_reg);
    assign s_w     = pos_w + hdr_w + r_w;
    assign data_w  = (pos_w + hdr_w) * align_w;
    assign sum_w   = gran_w + ARITH_W'(span_reg);
    assign fit     = (gran_w * align_w) >= req_w;
    assign split   = ((HDR_G != 0) || (r_reg != '0)) && (gran_w >= r_w + hdr_w + 1'b1);

    always_comb
    begin
        p_start        = h_start;
        p_used         = h_used;
        p_gran         = h_gran;
        found_next     = found_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        pend_gran_next = pend_gran_reg;
        flag_next      = flag_reg;
        span_next      = span_reg;
        res_off_next   = res_off_reg;
        unique case (state_reg)
            S_ALLOC:
            begin
                if (!found_reg && h_start && !h_used && fit)
                begin
                    p_used       = 1'b1;
                    found_next   = 1'b1;
                    res_off_next = data_w[BYTES_W-1:0];
                    if (split && (s_w < ARITH_W'(NUM_G)))
                    begin
                        p_gran         = GW'(r_w);
                        pend_next      = 1'b1;
                        pend_pos_next  = PW'(s_w);
                        pend_gran_next = GW'(gran_w - r_w - hdr_w);
                    end
                end
                else if (pend_reg && (cnt_reg == pend_pos_reg))
                begin
                    // remainder of the split block becomes a free block
                    p_start   = 1'b1;
                    p_used    = 1'b0;
                    p_gran    = pend_gran_reg;
                    pend_next = 1'b0;
                end
            end
            S_FIND:
            begin
                if (h_start && (data_w == ARITH_W'(off_reg)))
                begin
                    p_used     = 1'b0;
                    found_next = 1'b1;
                end
            end
            S_MERGE_B:
            begin
                // walking down: each free block absorbs the free run above it
                if (h_start)
                begin
                    if (!h_used)
                    begin
                        if (flag_reg)
                            p_gran = GW'(sum_w);
                        flag_next = 1'b1;
                        span_next = GW'(hdr_w + ARITH_W'(p_gran));
                    end
                    else
                    begin
                        flag_next = 1'b0;
                    end
                end
            end
            S_MERGE_C:
            begin
                // walking up: a free block after a free block loses its header
                if (h_start)
                begin
                    if (!h_used)
                    begin
                        if (flag_reg)
                            p_start = 1'b0;
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        flag_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                    state_next = (operation == OP_FREE) ? S_FIND : S_ALLOC;
            S_ALLOC:
                if (last)
                    state_next = S_FINISH;
            S_FIND:
                if (last)
                    state_next = found_next ? S_MERGE_B : S_FINISH;
            S_MERGE_B:
                if (last)
                    state_next = S_MERGE_C;
            S_MERGE_C:
                if (last)
                    state_next = S_FINISH;
            S_FINISH:
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            flag_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            res_st_reg    <= ST_ALLOCATED;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && (!rsp_valid_reg || !rsp_stall))
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    pend_reg  <= 1'b0;
                    flag_reg  <= 1'b0;
                end
                S_ALLOC, S_FIND, S_MERGE_B, S_MERGE_C:
                begin
                    cnt_reg   <= last ? '0 : cnt_reg + 1'b1;
                    found_reg <= found_next;
                    pend_reg  <= pend_next;
                    flag_reg  <= last ? 1'b0 : flag_next;
                    if (last)
                    begin
                        if (state_reg == S_ALLOC)
                            res_st_reg <= found_next ? ST_ALLOCATED : ST_NO_FIT;
                        else if (state_reg == S_FIND)
                            res_st_reg <= ST_NOT_FOUND;
                        else
                            res_st_reg <= ST_FREED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            op_reg      <= operation;
            req_reg     <= request_bytes;
            off_reg     <= free_offset;
            r_reg       <= recip_prod[RECIP_SHIFT +: ROUND_W];
            res_off_reg <= '0;
        end
        else
        begin
            res_off_reg <= res_off_next;
        end
        pend_pos_reg  <= pend_pos_next;
        pend_gran_reg <= pend_gran_next;
        span_reg      <= span_next;
        if (state_reg == S_FINISH && (!rsp_valid_reg || !rsp_stall))
        begin
            status_reg <= res_st_reg;
            offset_reg <= (op_reg == OP_ALLOC && res_st_reg == ST_ALLOCATED) ?
                          res_off_reg : '0;
        end
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign data_offset = offset_reg;

endmodule

[test/ffa_checker.sv]
`timescale 1ns / 1ps

module ffa_checker
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic        operation,
    input  logic [9:0]  request_bytes,
    input  logic [9:0]  free_offset,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [1:0]  status,
    input  logic [9:0]  data_offset,
    output int          fail_count,
    output int          pending,
    output int          grants,
    output int          frees_done,
    output int          misses
);

    localparam int NUM_G = 64;
    localparam int HDR_G = 1;
    localparam int GRAN  = 16;

    typedef struct packed {
        logic [1:0] st;
        logic [9:0] off;
    } alloc_result_t;

    bit       blk_start [NUM_G];
    bit       blk_used  [NUM_G];
    int       blk_gran  [NUM_G];
    alloc_result_t expected_q[$];

    function automatic alloc_result_t arena_step(logic op, logic [9:0] req, logic [9:0] off);
        alloc_result_t res;
        int g, n, r, s, guard;
        g = 0;
        guard = 0;
        res.st = (op == OP_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
        res.off = '0;
        if (op == OP_ALLOC) begin
            r = (int'(req) + GRAN - 1) / GRAN;
            while (g < NUM_G && guard < NUM_G + 1) begin
                n = g + HDR_G + blk_gran[g];
                guard++;
                if (blk_start[g] && !blk_used[g] && blk_gran[g] * GRAN >= int'(req)) begin
                    blk_used[g] = 1;
                    if (HDR_G + r > 0 && blk_gran[g] >= r + HDR_G + 1) begin
                        s = g + HDR_G + r;
                        if (s < NUM_G) begin
                            blk_start[s] = 1;
                            blk_used[s] = 0;
                            blk_gran[s] = blk_gran[g] - r - HDR_G;
                            blk_gran[g] = r;
                        end
                    end
                    res.st = ST_ALLOCATED;
                    res.off = 10'((g + HDR_G) * GRAN);
                    return res;
                end
                if (n <= g)
                    break;
                g = n;
            end
            return res;
        end
        while (g < NUM_G && guard < NUM_G + 1) begin
            n = g + HDR_G + blk_gran[g];
            guard++;
            if (blk_start[g] && (g + HDR_G) * GRAN == int'(off)) begin
                blk_used[g] = 0;
                coalesce();
                res.st = ST_FREED;
                return res;
            end
            if (n <= g)
                break;
            g = n;
        end
        return res;
    endfunction

    function automatic void coalesce();
        int g, n, guard;
        g = 0;
        guard = 0;
        while (g < NUM_G && guard < 2 * NUM_G + 2) begin
            n = g + HDR_G + blk_gran[g];
            guard++;
            if (n <= g)
                break;
            if (n < NUM_G && blk_start[n] && !blk_used[g] && !blk_used[n]) begin
                blk_gran[g] += HDR_G + blk_gran[n];
                blk_start[n] = 0;
                blk_used[n] = 0;
            end
            else
                g = n;
        end
    endfunction

    initial
    begin
        fail_count = 0;
        grants = 0;
        frees_done = 0;
        misses = 0;
        for (int i = 0; i < NUM_G; i++)
        begin
            blk_start[i] = 0;
            blk_used[i] = 0;
            blk_gran[i] = 0;
        end
        blk_start[0] = 1;
        blk_gran[0] = NUM_G - HDR_G;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        alloc_result_t exp_res;
        if (rst_n && req_valid && !req_stall)
            expected_q.push_back(arena_step(operation, request_bytes, free_offset));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d offset=%0d",
                         $time, status, data_offset);
                fail_count++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (status !== exp_res.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_res.st, status);
                    fail_count++;
                end
                if (data_offset !== exp_res.off)
                begin
                    $display("%0t: data_offset expected %0d actual %0d",
                             $time, exp_res.off, data_offset);
                    fail_count++;
                end
                case (exp_res.st)
                    ST_ALLOCATED: grants++;
                    ST_FREED:     frees_done++;
                    default:      misses++;
                endcase
            end
        end
    end

endmodule

[test/tb_first_fit_block_allocator.sv]
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
    import ffa_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    logic       operation;
    logic [9:0] request_bytes;
    logic [9:0] free_offset;
    logic       rsp_valid;
    logic       rsp_stall;
    logic [1:0] status;
    logic [9:0] data_offset;
    int         fail_count;
    int         pending;
    int         grants;
    int         frees_done;
    int         misses;
    bit         calm_tail;

    // offsets handed out so far, used to build frees that hit
    logic [9:0] granted[$];

    first_fit_block_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .operation(operation), .request_bytes(request_bytes), .free_offset(free_offset),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .status(status), .data_offset(data_offset)
    );

    ffa_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .operation(operation), .request_bytes(request_bytes), .free_offset(free_offset),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .status(status), .data_offset(data_offset),
        .fail_count(fail_count), .pending(pending),
        .grants(grants), .frees_done(frees_done), .misses(misses)
    );

    initial clk = 0;
    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // note granted offsets from the response side
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall && status == ST_ALLOCATED)
            granted.push_back(data_offset);
    end

    // response stall bursts
    initial
    begin
        int n;
        rsp_stall = 0;
        @(posedge rst_n);
        forever
        begin
            if (!calm_tail && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 19);
                rsp_stall <= 1;
                repeat (n) @(posedge clk);
                rsp_stall <= 0;
            end
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    task automatic send_request(logic op, logic [9:0] req, logic [9:0] off);
        int n;
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 19);
            repeat (n) @(posedge clk);
        end
        req_valid <= 1;
        operation <= op;
        request_bytes <= req;
        free_offset <= off;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        req_valid <= 0;
        // the block is busy for a whole walk after taking a request
        @(posedge clk);
    endtask

    task automatic drain_requests();
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int pick, idx;
        logic [9:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            // mostly small sizes so the arena fragments
            if ($urandom_range(0, 7) == 0)
                send_request(OP_ALLOC, 10'($urandom), 10'($urandom));
            else
                send_request(OP_ALLOC, 10'($urandom_range(0, 120)), 10'($urandom));
        end
        else if (pick < 88 && granted.size() != 0)
        begin
            idx = $urandom_range(0, granted.size() - 1);
            off = granted[idx];
            granted.delete(idx);
            send_request(OP_FREE, 10'($urandom), off);
        end
        else if (pick < 94)
            send_request(OP_FREE, 10'($urandom), 10'($urandom_range(1, 63) * 16));
        else
            send_request(OP_FREE, 10'($urandom), 10'($urandom));
    endtask

    initial
    begin
        req_valid = 0;
        operation = OP_ALLOC;
        request_bytes = '0;
        free_offset = '0;
        calm_tail = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // whole arena, then nothing left, then free it back
        send_request(OP_ALLOC, 10'd1008, 10'd0);
        send_request(OP_ALLOC, 10'd0, 10'd0);
        send_request(OP_FREE, 10'd0, 10'd16);
        // too big for the arena
        send_request(OP_ALLOC, 10'd1023, 10'h3FF);
        // zero-byte request splits off a remainder
        send_request(OP_ALLOC, 10'd0, 10'd0);
        send_request(OP_ALLOC, 10'd1, 10'd0);
        send_request(OP_ALLOC, 10'd16, 10'd0);
        send_request(OP_ALLOC, 10'd17, 10'd0);
        // free of an address inside an allocated block, twice, then misaligned and unknown addresses
        send_request(OP_FREE, 10'd0, 10'd48);
        send_request(OP_FREE, 10'd0, 10'd48);
        send_request(OP_FREE, 10'd0, 10'd49);
        send_request(OP_FREE, 10'd0, 10'd0);
        send_request(OP_FREE, 10'h3FF, 10'h3FF);
        send_request(OP_FREE, 10'd0, 10'd16);
        send_request(OP_FREE, 10'd0, 10'd32);
        send_request(OP_FREE, 10'd0, 10'd80);
        // remainder too small to split
        send_request(OP_ALLOC, 10'd992, 10'd0);
        send_request(OP_ALLOC, 10'd1, 10'd0);
        send_request(OP_FREE, 10'd0, 10'd16);
        send_request(OP_FREE, 10'd0, 10'd1008);
        granted.delete();
        drain_requests();

        for (int i = 0; i < 1600; i++)
        begin
            if (i == 700)
                drain_requests();
            if (i == 1400)
                calm_tail = 1;
            send_random();
        end

        drain_requests();
        repeat (200) @(posedge clk);
        $display("run: %0d grants, %0d frees, %0d no-fit or unknown-address responses",
                 grants, frees_done, misses);
        if (fail_count == 0 && pending == 0)
            $display("first_fit_block_allocator verification clean");
        else
            $display("first_fit_block_allocator verification failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("first_fit_block_allocator verification failed");
        $finish;
    end

endmodule

[files.f]
src/ffa_pkg.sv
src/ffa_cell.sv
src/first_fit_block_allocator.sv
test/ffa_checker.sv
test/tb_first_fit_block_allocator.sv
